// ----- src/ddof_pkg.sv -----
// ----------------------------------------------------------------------------
// ddof_pkg
// Shared types, constants and the arctangent table for the odometry and gyro
// fusion block.
// ----------------------------------------------------------------------------
package ddof_pkg;

  // Field widths.
  localparam int IN_W       = 16;
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int THR_W      = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Fixed-point shifts.
  localparam int GAIN_SHIFT = 12;
  localparam int TRIG_SHIFT = 15;
  localparam int DX_SHIFT   = 27;
  localparam int DH_SHIFT   = 44;

  // CORDIC datapath.
  localparam int CORDIC_STEPS = 14;
  localparam int ITER_W       = 4;
  localparam int CORDIC_W     = 34;
  localparam int ANG_W        = 18;
  localparam int TRIG_W       = 18;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0    = 34'sd652032874;
  localparam logic signed [ANG_W-1:0]    QUARTER_TURN = 18'sd16384;
  localparam logic signed [ANG_W-1:0]    HALF_TURN    = 18'sd32768;

  // Shared multiplier and intermediate widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = 64;
  localparam int GS_W    = 24;
  localparam logic signed [MUL_B_W-1:0] RAD_TO_BAM = 32'sd683565276;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] WHEEL_RATE_GAIN_RST = 16'd21500;
  localparam logic [CFG_DATA_W-1:0] GYRO_GAIN_RST       = 16'd4588;
  localparam logic [THR_W-1:0]      AGREE_THRESHOLD_RST = 15'd82;
  localparam logic [CFG_DATA_W-1:0] FUSION_GAIN_RST     = 16'd3645;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_RATE_GAIN = 2'd0,
    REG_GYRO_GAIN       = 2'd1,
    REG_AGREE_THRESHOLD = 2'd2,
    REG_FUSION_GAIN     = 2'd3
  } cfg_reg_t;

  // Microprogram step addresses.
  typedef logic [4:0] step_t;
  localparam step_t STEP_LOAD        = 5'd0;
  localparam step_t STEP_MUL_GG      = 5'd1;
  localparam step_t STEP_GYRO_SCALE  = 5'd2;
  localparam step_t STEP_MUL_WG      = 5'd3;
  localparam step_t STEP_WHEEL_AVG   = 5'd4;
  localparam step_t STEP_MUL_FG      = 5'd5;
  localparam step_t STEP_TURN        = 5'd6;
  localparam step_t STEP_CORDIC      = 5'd7;
  localparam step_t STEP_TRIG        = 5'd8;
  localparam step_t STEP_MUL_FC      = 5'd9;
  localparam step_t STEP_MUL_XD      = 5'd10;
  localparam step_t STEP_X_UPD       = 5'd11;
  localparam step_t STEP_MUL_FS      = 5'd12;
  localparam step_t STEP_MUL_YD      = 5'd13;
  localparam step_t STEP_Y_UPD       = 5'd14;
  localparam step_t STEP_MUL_TD      = 5'd15;
  localparam step_t STEP_MUL_PR      = 5'd16;
  localparam step_t STEP_H_UPD       = 5'd17;
  localparam step_t STEP_EMIT        = 5'd18;

  // Datapath micro-operations.
  typedef enum logic [4:0] {
    UOP_LOAD,
    UOP_MUL_GG,
    UOP_GYRO_SCALE,
    UOP_MUL_WG,
    UOP_WHEEL_AVG,
    UOP_MUL_FG,
    UOP_TURN,
    UOP_CORDIC,
    UOP_TRIG,
    UOP_MUL_FC,
    UOP_MUL_PD,
    UOP_X_UPD,
    UOP_MUL_FS,
    UOP_Y_UPD,
    UOP_MUL_TD,
    UOP_MUL_PR,
    UOP_H_UPD,
    UOP_EMIT
  } uop_t;

  // Sequencing conditions.
  typedef enum logic [1:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_LOOP,
    COND_WAIT_OUT
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    uop_t op;
    logic fire;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic iter_last;
    logic out_busy;
  } status_t;

  // Arctangent of 2^-i as a binary angle.
  function automatic logic signed [ANG_W-1:0] atan_bam(input logic [ITER_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    unique case (i)
      4'd0:    a = 18'sd8192;
      4'd1:    a = 18'sd4836;
      4'd2:    a = 18'sd2555;
      4'd3:    a = 18'sd1297;
      4'd4:    a = 18'sd651;
      4'd5:    a = 18'sd326;
      4'd6:    a = 18'sd163;
      4'd7:    a = 18'sd81;
      4'd8:    a = 18'sd41;
      4'd9:    a = 18'sd20;
      4'd10:   a = 18'sd10;
      4'd11:   a = 18'sd5;
      4'd12:   a = 18'sd3;
      4'd13:   a = 18'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- src/ddof_seq.sv -----
// ----------------------------------------------------------------------------
// ddof_seq
// Microprogram sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module ddof_seq import ddof_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t  step;
  step_t  step_next;
  uword_t uw;

  // Control store: one word per step.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      STEP_LOAD:       w = '{op: UOP_LOAD,       cond: COND_WAIT_IN,  target: STEP_LOAD};
      STEP_MUL_GG:     w = '{op: UOP_MUL_GG,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_GYRO_SCALE: w = '{op: UOP_GYRO_SCALE, cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_WG:     w = '{op: UOP_MUL_WG,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_WHEEL_AVG:  w = '{op: UOP_WHEEL_AVG,  cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_FG:     w = '{op: UOP_MUL_FG,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_TURN:       w = '{op: UOP_TURN,       cond: COND_NEXT,     target: STEP_LOAD};
      STEP_CORDIC:     w = '{op: UOP_CORDIC,     cond: COND_LOOP,     target: STEP_CORDIC};
      STEP_TRIG:       w = '{op: UOP_TRIG,       cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_FC:     w = '{op: UOP_MUL_FC,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_XD:     w = '{op: UOP_MUL_PD,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_X_UPD:      w = '{op: UOP_X_UPD,      cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_FS:     w = '{op: UOP_MUL_FS,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_YD:     w = '{op: UOP_MUL_PD,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_Y_UPD:      w = '{op: UOP_Y_UPD,      cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_TD:     w = '{op: UOP_MUL_TD,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_PR:     w = '{op: UOP_MUL_PR,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_H_UPD:      w = '{op: UOP_H_UPD,      cond: COND_NEXT,     target: STEP_LOAD};
      STEP_EMIT:       w = '{op: UOP_EMIT,       cond: COND_WAIT_OUT, target: STEP_LOAD};
      default:         w = '{op: UOP_EMIT,       cond: COND_WAIT_OUT, target: STEP_LOAD};
    endcase
    return w;
  endfunction

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

  // Decode the current word and pick the next step.
  always_comb begin
    uw        = ucode(step);
    ctrl.op   = uw.op;
    ctrl.fire = 1'b1;
    step_next = step_t'(step + 1'b1);
    unique case (uw.cond)
      COND_NEXT: begin
        step_next = step_t'(step + 1'b1);
      end
      COND_WAIT_IN: begin
        ctrl.fire = in_valid;
        step_next = in_valid ? step_t'(step + 1'b1) : step;
      end
      COND_LOOP: begin
        step_next = status.iter_last ? step_t'(step + 1'b1) : uw.target;
      end
      COND_WAIT_OUT: begin
        ctrl.fire = !status.out_busy;
        step_next = status.out_busy ? step : uw.target;
      end
      default: begin
        step_next = STEP_LOAD;
      end
    endcase
  end

  // Requests are taken only at the load step.
  assign in_stall = (uw.cond != COND_WAIT_IN);

  // The step counter stays inside the program.
  assert property (@(posedge clk) disable iff (rst) step <= STEP_EMIT)
    else $error("step counter left the program");

  // An accepted request starts the computation at the next step.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> step == STEP_MUL_GG)
    else $error("accepted request did not start the program");

  // A blocked output holds the sequencer at the emit step.
  assert property (@(posedge clk) disable iff (rst)
    step == STEP_EMIT && status.out_busy |=> step == STEP_EMIT)
    else $error("emit step left while output was busy");

endmodule

// ----- src/ddof_dp.sv -----
// ----------------------------------------------------------------------------
// ddof_dp
// Datapath: configuration registers, shared multiplier, CORDIC rotator,
// pose accumulators and the output register.
// ----------------------------------------------------------------------------
module ddof_dp import ddof_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [IN_W-1:0]       left_speed,
  input  logic signed [IN_W-1:0]       right_speed,
  input  logic signed [IN_W-1:0]       gyro_rate,
  input  logic [IN_W-1:0]              time_step,
  input  ctrl_t                        ctrl,
  output status_t                      status,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic signed [POS_W-1:0]      pos_x,
  output logic signed [POS_W-1:0]      pos_y,
  output logic [HEAD_W-1:0]            heading,
  output logic signed [IN_W-1:0]       forward_speed,
  output logic signed [IN_W-1:0]       turn_rate
);

  localparam int WSUM_W = GS_W + 1;
  localparam int XSUM_W = POS_W + 2;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] wheel_rate_gain;
  logic [CFG_DATA_W-1:0] gyro_gain;
  logic [THR_W-1:0]      agree_threshold;
  logic [CFG_DATA_W-1:0] fusion_gain;

  // Working registers.
  logic signed [IN_W-1:0]     gyro;
  logic signed [IN_W:0]       diff;
  logic signed [IN_W-1:0]     fwd;
  logic [IN_W-1:0]            dt;
  logic                       agree;
  logic signed [ANG_W-1:0]    z;
  logic                       flip;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic [ITER_W-1:0]          iter;
  logic signed [GS_W-1:0]     gs;
  logic signed [GS_W-1:0]     wavg;
  logic signed [IN_W-1:0]     turn;
  logic signed [TRIG_W-1:0]   cosv;
  logic signed [TRIG_W-1:0]   sinv;
  logic signed [PROD_W-1:0]   prod;

  // Pose state.
  logic signed [POS_W-1:0] x_acc;
  logic signed [POS_W-1:0] y_acc;
  logic [HEAD_W-1:0]       yaw_acc;

  // Combinational values.
  logic signed [IN_W:0]               sum_lr;
  logic signed [IN_W:0]               diff_in;
  logic [IN_W:0]                      adiff_in;
  logic signed [ANG_W-1:0]            z_raw;
  logic signed [ANG_W-1:0]            z_in;
  logic                               flip_in;
  logic signed [CORDIC_W-1:0]         xs;
  logic signed [CORDIC_W-1:0]         ys;
  logic signed [CORDIC_W-1:0]         xf;
  logic signed [CORDIC_W-1:0]         yf;
  logic signed [PROD_W-1:0]           prod_sh;
  logic signed [WSUM_W-1:0]           wsum;
  logic signed [XSUM_W-1:0]           xsum;
  logic signed [XSUM_W-1:0]           ysum;
  logic signed [MUL_A_W-1:0]          mul_a;
  logic signed [MUL_B_W-1:0]          mul_b;
  logic signed [MUL_A_W+MUL_B_W-1:0]  prod_full;

  // Saturate to the 16-bit signed range.
  function automatic logic signed [IN_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [IN_W-1:0] r;
    if (v > PROD_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -PROD_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[IN_W-1:0];
    end
    return r;
  endfunction

  // Saturate a grown position sum to the 32-bit signed range.
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [XSUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > XSUM_W'(64'sh7fff_ffff)) begin
      r = 32'sh7fff_ffff;
    end else if (v < XSUM_W'(-64'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Input decode, heading fold and the per-step arithmetic.
  always_comb begin
    sum_lr   = IN_W'(0) + $signed({left_speed[IN_W-1], left_speed})
             + $signed({right_speed[IN_W-1], right_speed});
    diff_in  = $signed({left_speed[IN_W-1], left_speed})
             - $signed({right_speed[IN_W-1], right_speed});
    adiff_in = diff_in[IN_W] ? (IN_W+1)'(-diff_in) : diff_in;

    // Fold the heading into plus or minus a quarter turn.
    z_raw   = ANG_W'($signed(yaw_acc));
    z_in    = z_raw;
    flip_in = 1'b0;
    if (z_raw > QUARTER_TURN) begin
      z_in    = z_raw - HALF_TURN;
      flip_in = 1'b1;
    end else if (z_raw < -QUARTER_TURN) begin
      z_in    = z_raw + HALF_TURN;
      flip_in = 1'b1;
    end

    xs = cx >>> iter;
    ys = cy >>> iter;
    xf = flip ? -cx : cx;
    yf = flip ? -cy : cy;

    prod_sh = prod >>> GAIN_SHIFT;
    wsum    = WSUM_W'(prod_sh) + WSUM_W'(gs);
    xsum    = XSUM_W'(x_acc) + XSUM_W'(prod >>> DX_SHIFT);
    ysum    = XSUM_W'(y_acc) + XSUM_W'(prod >>> DX_SHIFT);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctrl.op)
      UOP_MUL_GG: begin
        mul_a = MUL_A_W'(gyro);
        mul_b = MUL_B_W'($signed({1'b0, gyro_gain}));
      end
      UOP_MUL_WG: begin
        mul_a = MUL_A_W'(diff);
        mul_b = MUL_B_W'($signed({1'b0, wheel_rate_gain}));
      end
      UOP_MUL_FG: begin
        mul_a = MUL_A_W'(wavg);
        mul_b = MUL_B_W'($signed({1'b0, fusion_gain}));
      end
      UOP_MUL_FC: begin
        mul_a = MUL_A_W'(fwd);
        mul_b = MUL_B_W'(cosv);
      end
      UOP_MUL_FS: begin
        mul_a = MUL_A_W'(fwd);
        mul_b = MUL_B_W'(sinv);
      end
      UOP_MUL_PD: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'($signed({1'b0, dt}));
      end
      UOP_MUL_TD: begin
        mul_a = MUL_A_W'(turn);
        mul_b = MUL_B_W'($signed({1'b0, dt}));
      end
      UOP_MUL_PR: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = RAD_TO_BAM;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_full = mul_a * mul_b;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_rate_gain <= WHEEL_RATE_GAIN_RST;
      gyro_gain       <= GYRO_GAIN_RST;
      agree_threshold <= AGREE_THRESHOLD_RST;
      fusion_gain     <= FUSION_GAIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WHEEL_RATE_GAIN: wheel_rate_gain <= cfg_data;
        REG_GYRO_GAIN:       gyro_gain       <= cfg_data;
        REG_AGREE_THRESHOLD: agree_threshold <= cfg_data[THR_W-1:0];
        REG_FUSION_GAIN:     fusion_gain     <= cfg_data;
        default:             fusion_gain     <= fusion_gain;
      endcase
    end
  end

  // Pose state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc     <= '0;
      y_acc     <= '0;
      yaw_acc   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.fire && ctrl.op == UOP_X_UPD) begin
        x_acc <= sat32(xsum);
      end
      if (ctrl.fire && ctrl.op == UOP_Y_UPD) begin
        y_acc <= sat32(ysum);
      end
      if (ctrl.fire && ctrl.op == UOP_H_UPD) begin
        yaw_acc <= yaw_acc + prod[DH_SHIFT +: HEAD_W];
      end
      if (ctrl.fire && ctrl.op == UOP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers, one micro-operation per step.
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      unique case (ctrl.op)
        UOP_LOAD: begin
          gyro  <= gyro_rate;
          diff  <= diff_in;
          fwd   <= sum_lr[IN_W:1];
          dt    <= time_step;
          agree <= (adiff_in < (IN_W+1)'(agree_threshold));
          z     <= z_in;
          flip  <= flip_in;
          cx    <= CORDIC_X0;
          cy    <= '0;
          iter  <= '0;
        end
        UOP_MUL_GG, UOP_MUL_WG, UOP_MUL_FG, UOP_MUL_FC, UOP_MUL_FS,
        UOP_MUL_PD, UOP_MUL_TD, UOP_MUL_PR: begin
          prod <= prod_full[PROD_W-1:0];
        end
        UOP_GYRO_SCALE: begin
          gs <= GS_W'(prod_sh);
        end
        UOP_WHEEL_AVG: begin
          wavg <= GS_W'(wsum >>> 1);
        end
        UOP_TURN: begin
          turn <= agree ? sat16(PROD_W'(gs)) : sat16(prod_sh);
        end
        UOP_CORDIC: begin
          if (!z[ANG_W-1]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            z  <= z - atan_bam(iter);
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            z  <= z + atan_bam(iter);
          end
          iter <= iter + 1'b1;
        end
        UOP_TRIG: begin
          cosv <= xf[TRIG_SHIFT +: TRIG_W];
          sinv <= yf[TRIG_SHIFT +: TRIG_W];
        end
        UOP_EMIT: begin
          pos_x         <= x_acc;
          pos_y         <= y_acc;
          heading       <= yaw_acc;
          forward_speed <= fwd;
          turn_rate     <= turn;
        end
        default: begin
          iter <= iter;
        end
      endcase
    end
  end

  assign status.iter_last = (iter == ITER_W'(CORDIC_STEPS - 1));
  assign status.out_busy  = out_valid && out_stall;

  // An emitted pose is presented on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.op == UOP_EMIT |=> out_valid)
    else $error("emitted pose not presented");

  // Each load restarts the CORDIC iteration count.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.op == UOP_LOAD |=> iter == '0)
    else $error("CORDIC count not cleared on load");

  // The heading moves only at the heading update step.
  assert property (@(posedge clk) disable iff (rst)
    !(ctrl.fire && ctrl.op == UOP_H_UPD) |=> $stable(yaw_acc))
    else $error("heading changed outside its update step");

endmodule

// ----- src/diff_drive_odometry_gyro_fusion_unit.sv -----
// A new request is accepted only at the load step, once the pose of the
// previous one has been emitted; emitting waits while the output is stalled.
// The CORDIC loop and the single shared multiplier set the pace of a request.
// A finished pose waits in the output register while the next request runs.
// Reset (synchronous, active high) zeroes the pose, loads the default gains
// and returns the sequencer to its load step; no clearing pass is needed.
// ----------------------------------------------------------------------------
// diff_drive_odometry_gyro_fusion_unit
// Differential-drive dead reckoning fused with a gyro yaw rate, built as a
// microcoded sequencer driving one multiplier and a CORDIC rotator.
// ----------------------------------------------------------------------------
module diff_drive_odometry_gyro_fusion_unit import ddof_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  left_speed,
  input  logic signed [IN_W-1:0]  right_speed,
  input  logic signed [IN_W-1:0]  gyro_rate,
  input  logic [IN_W-1:0]         time_step,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic [HEAD_W-1:0]       heading,
  output logic signed [IN_W-1:0]  forward_speed,
  output logic signed [IN_W-1:0]  turn_rate
);

  ctrl_t   ctrl;
  status_t status;

  // Sequencer.
  ddof_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctrl     (ctrl)
  );

  // Datapath.
  ddof_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .left_speed    (left_speed),
    .right_speed   (right_speed),
    .gyro_rate     (gyro_rate),
    .time_step     (time_step),
    .ctrl          (ctrl),
    .status        (status),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .heading       (heading),
    .forward_speed (forward_speed),
    .turn_rate     (turn_rate)
  );

endmodule

// ----- tb/sv/odometry_pose_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_pose_checker
// Watches the register port and both request channels of the odometry and
// gyro fusion block. Every accepted request is run through a local model of
// the pose integrator, and the predicted pose is queued. Every accepted output
// pose is compared with the oldest queued prediction.
// ----------------------------------------------------------------------------
module odometry_pose_checker import ddof_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [IN_W-1:0]  left_speed,
  input  logic signed [IN_W-1:0]  right_speed,
  input  logic signed [IN_W-1:0]  gyro_rate,
  input  logic [IN_W-1:0]         time_step,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [HEAD_W-1:0]       heading,
  input  logic signed [IN_W-1:0]  forward_speed,
  input  logic signed [IN_W-1:0]  turn_rate,
  output int                      fail_count,
  output int                      pending,
  output int                      poses_checked,
  output int                      agree_ticks,
  output int                      fused_ticks,
  output int                      clamped_ticks
);

  localparam int     MAX_REPORTS = 10;
  localparam int     ROT_STEPS   = 14;
  localparam longint ROT_SEED    = 652032874;   // 1/K of the rotator in Q2.30
  localparam longint RAD2BAM     = 683565276;   // 65536 / (2*pi) in Q16.16
  localparam longint POS_MIN     = -64'sd2147483648;
  localparam longint POS_MAX     = 64'sd2147483647;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [HEAD_W-1:0]        heading;
    logic signed [IN_W-1:0]   forward_speed;
    logic signed [IN_W-1:0]   turn_rate;
  } pose_t;

  // Register shadows and integrator state.
  longint wheel_gain_q;
  longint gyro_gain_q;
  longint agree_thr_q;
  longint fusion_gain_q;
  longint pose_x;
  longint pose_y;
  logic [HEAD_W-1:0] yaw;

  pose_t expected_poses[$];
  pose_t got;
  pose_t want;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Arctangent of 2^-i in binary angle units.
  function automatic longint arctan_step(input int i);
    case (i)
      0:       return 8192;
      1:       return 4836;
      2:       return 2555;
      3:       return 1297;
      4:       return 651;
      5:       return 326;
      6:       return 163;
      7:       return 81;
      8:       return 41;
      9:       return 20;
      10:      return 10;
      11:      return 5;
      12:      return 3;
      13:      return 1;
      default: return 0;
    endcase
  endfunction

  // Cosine and sine of a binary angle in Q.15. The angle is folded into the
  // right half plane first and the signs are restored afterwards.
  function automatic void rotate_heading(input logic [HEAD_W-1:0] ang,
                                         output longint cos_q, output longint sin_q);
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint z;
    bit     flip;
    x    = ROT_SEED;
    y    = 0;
    z    = longint'($signed(ang));
    flip = 1'b0;
    if (z > 16384) begin
      z    = z - 32768;
      flip = 1'b1;
    end else if (z < -16384) begin
      z    = z + 32768;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_step(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_step(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q = x >>> TRIG_SHIFT;
    sin_q = y >>> TRIG_SHIFT;
  endfunction

  // Advance the integrator by one request and return the pose it produces.
  function automatic pose_t advance_pose(input logic signed [IN_W-1:0] l16,
                                         input logic signed [IN_W-1:0] r16,
                                         input logic signed [IN_W-1:0] g16,
                                         input logic [IN_W-1:0] dt16);
    longint l;
    longint r;
    longint g;
    longint dt;
    longint fwd;
    longint diff;
    longint gyro_s;
    longint wheel_r;
    longint turn;
    longint c;
    longint s;
    longint nx;
    longint ny;
    longint dh;
    pose_t  p;
    l      = longint'(l16);
    r      = longint'(r16);
    g      = longint'(g16);
    dt     = longint'(dt16);
    fwd    = (l + r) >>> 1;
    diff   = l - r;
    gyro_s = (g * gyro_gain_q) >>> GAIN_SHIFT;

    // Trust the gyro alone when the wheels agree, otherwise blend both rates.
    if (((diff < 0) ? -diff : diff) < agree_thr_q) begin
      turn = gyro_s;
      agree_ticks++;
    end else begin
      wheel_r = (diff * wheel_gain_q) >>> GAIN_SHIFT;
      turn    = (((wheel_r + gyro_s) >>> 1) * fusion_gain_q) >>> GAIN_SHIFT;
      fused_ticks++;
    end
    turn = clamp(turn, -32768, 32767);

    // Position moves along the old heading, then the heading advances.
    rotate_heading(yaw, c, s);
    nx = pose_x + ((fwd * c * dt) >>> DX_SHIFT);
    ny = pose_y + ((fwd * s * dt) >>> DX_SHIFT);
    if (nx != clamp(nx, POS_MIN, POS_MAX) || ny != clamp(ny, POS_MIN, POS_MAX)) begin
      clamped_ticks++;
    end
    pose_x = clamp(nx, POS_MIN, POS_MAX);
    pose_y = clamp(ny, POS_MIN, POS_MAX);
    dh     = (turn * dt * RAD2BAM) >>> DH_SHIFT;
    yaw    = yaw + dh[HEAD_W-1:0];

    p.pos_x         = pose_x[POS_W-1:0];
    p.pos_y         = pose_y[POS_W-1:0];
    p.heading       = yaw;
    p.forward_speed = fwd[IN_W-1:0];
    p.turn_rate     = turn[IN_W-1:0];
    return p;
  endfunction

  // Track register writes, check output poses and predict new ones.
  always @(posedge clk) begin
    if (rst) begin
      wheel_gain_q  = longint'(WHEEL_RATE_GAIN_RST);
      gyro_gain_q   = longint'(GYRO_GAIN_RST);
      agree_thr_q   = longint'(AGREE_THRESHOLD_RST);
      fusion_gain_q = longint'(FUSION_GAIN_RST);
      pose_x        = 0;
      pose_y        = 0;
      yaw           = '0;
      expected_poses.delete();
      fail_count    = 0;
      poses_checked = 0;
      agree_ticks   = 0;
      fused_ticks   = 0;
      clamped_ticks = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_WHEEL_RATE_GAIN: wheel_gain_q  = longint'(cfg_data);
          REG_GYRO_GAIN:       gyro_gain_q   = longint'(cfg_data);
          REG_AGREE_THRESHOLD: agree_thr_q   = longint'(cfg_data[THR_W-1:0]);
          REG_FUSION_GAIN:     fusion_gain_q = longint'(cfg_data);
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        got = '{pos_x, pos_y, heading, forward_speed, turn_rate};
        if (expected_poses.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: pose x=%0d y=%0d head=%0d arrived with no request outstanding",
                     $time, got.pos_x, got.pos_y, got.heading);
          end
        end else begin
          want = expected_poses.pop_front();
          poses_checked++;
          if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
              got.heading !== want.heading || got.forward_speed !== want.forward_speed ||
              got.turn_rate !== want.turn_rate) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: pose mismatch, expected x=%0d y=%0d head=%0d fwd=%0d turn=%0d",
                       $time, want.pos_x, want.pos_y, want.heading, want.forward_speed,
                       want.turn_rate);
              $display("%0t:                  actual x=%0d y=%0d head=%0d fwd=%0d turn=%0d",
                       $time, got.pos_x, got.pos_y, got.heading, got.forward_speed,
                       got.turn_rate);
            end
          end
        end
      end

      if (in_valid && !in_stall) begin
        expected_poses.push_back(advance_pose(left_speed, right_speed, gyro_rate, time_step));
      end
    end
    pending = expected_poses.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the odometry and gyro fusion block: a directed set of corner
// requests, then random phases under different gain settings and idling
// patterns, and a short straight drive at full speed with the heading held.
// A separate checker predicts and compares every pose.
// ----------------------------------------------------------------------------
module tb;
  import ddof_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int PHASE_ITEMS  = 380;
  localparam int DRIVE_OUT    = 120;
  localparam int DRIVE_BACK   = 40;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic signed [IN_W-1:0] left;
    logic signed [IN_W-1:0] right;
    logic signed [IN_W-1:0] gyro;
    logic [IN_W-1:0]        dt;
  } tick_t;

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data    = '0;
  logic                    in_valid    = 1'b0;
  logic signed [IN_W-1:0]  left_speed  = '0;
  logic signed [IN_W-1:0]  right_speed = '0;
  logic signed [IN_W-1:0]  gyro_rate   = '0;
  logic [IN_W-1:0]         time_step   = '0;
  logic                    out_stall   = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [HEAD_W-1:0]       heading;
  logic signed [IN_W-1:0]  forward_speed;
  logic signed [IN_W-1:0]  turn_rate;

  int fail_count;
  int pending;
  int poses_checked;
  int agree_ticks;
  int fused_ticks;
  int clamped_ticks;
  int cycles    = 0;
  int idle_pct  = 0;
  int stall_pct = 0;
  int thr_now   = int'(AGREE_THRESHOLD_RST);

  always #1 clk = ~clk;

  diff_drive_odometry_gyro_fusion_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .left_speed    (left_speed),
    .right_speed   (right_speed),
    .gyro_rate     (gyro_rate),
    .time_step     (time_step),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .heading       (heading),
    .forward_speed (forward_speed),
    .turn_rate     (turn_rate)
  );

  odometry_pose_checker pose_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .left_speed    (left_speed),
    .right_speed   (right_speed),
    .gyro_rate     (gyro_rate),
    .time_step     (time_step),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .heading       (heading),
    .forward_speed (forward_speed),
    .turn_rate     (turn_rate),
    .fail_count    (fail_count),
    .pending       (pending),
    .poses_checked (poses_checked),
    .agree_ticks   (agree_ticks),
    .fused_ticks   (fused_ticks),
    .clamped_ticks (clamped_ticks)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("diff_drive_odometry_gyro_fusion_unit verification failed");
      $finish;
    end
  end

  // Output side backpressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic int clamp16(input int v);
    return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
  endfunction

  function automatic tick_t mk_tick(input int l, input int r, input int g, input int dt);
    tick_t t;
    t.left  = l[IN_W-1:0];
    t.right = r[IN_W-1:0];
    t.gyro  = g[IN_W-1:0];
    t.dt    = dt[IN_W-1:0];
    return t;
  endfunction

  function automatic logic [IN_W-1:0] corner16();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return IN_W'($urandom_range(65535));
    endcase
  endfunction

  // One random request, biased toward the agree/fuse decision and the corners.
  function automatic tick_t random_tick();
    tick_t t;
    int    pick;
    int    d;
    pick    = $urandom_range(99);
    t.left  = IN_W'($urandom_range(65535));
    t.right = IN_W'($urandom_range(65535));
    t.gyro  = IN_W'($urandom_range(65535));
    t.dt    = IN_W'($urandom_range(65535));
    if (pick < 30 && thr_now > 0) begin
      // Wheels within the threshold of each other.
      d = $urandom_range(thr_now - 1);
      if ($urandom_range(1) == 1) d = -d;
      t.right = IN_W'(clamp16(int'(t.left) + d));
    end else if (pick < 40) begin
      // Difference right at the threshold or one below it.
      d = thr_now - $urandom_range(1);
      if ($urandom_range(1) == 1) d = -d;
      t.right = IN_W'(clamp16(int'(t.left) + d));
    end else if (pick < 55) begin
      t.left  = corner16();
      t.right = corner16();
      t.gyro  = corner16();
      t.dt    = corner16();
    end else if (pick < 62) begin
      t.dt = '0;
    end else if (pick < 77) begin
      t.left  = IN_W'(int'($urandom_range(1023)) - 512);
      t.right = IN_W'(int'($urandom_range(1023)) - 512);
      t.gyro  = IN_W'(int'($urandom_range(1023)) - 512);
    end
    return t;
  endfunction

  // Present one request and hold it until it is taken.
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    left_speed  <= t.left;
    right_speed <= t.right;
    gyro_rate   <= t.gyro;
    time_step   <= t.dt;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off new requests until every predicted pose has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Write all four registers back to back; called only while the block is idle.
  task automatic configure(input int wrg, input int gg, input int thr, input int fg);
    cfg_write <= 1'b1;
    cfg_index <= REG_WHEEL_RATE_GAIN;
    cfg_data  <= wrg[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_GYRO_GAIN;
    cfg_data  <= gg[CFG_DATA_W-1:0];
    @(posedge clk);
    // The unused top bit of the threshold write is random.
    cfg_index <= REG_AGREE_THRESHOLD;
    cfg_data  <= {1'($urandom_range(1)), thr[THR_W-1:0]};
    @(posedge clk);
    cfg_index <= REG_FUSION_GAIN;
    cfg_data  <= fg[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    thr_now   = int'(thr[THR_W-1:0]);
  endtask

  // Random requests under one idling pattern, with a full drain halfway.
  task automatic run_phase(input int idle, input int stall, input int count);
    idle_pct  = idle;
    stall_pct <= stall;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      send_tick(random_tick());
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners under the reset gains.
    send_tick(mk_tick(0, 0, 0, 0));
    send_tick(mk_tick(32767, 32767, 32767, 65535));
    send_tick(mk_tick(-32768, -32768, -32768, 65535));
    send_tick(mk_tick(32767, -32768, 32767, 65535));
    send_tick(mk_tick(-32768, 32767, -32768, 65535));
    send_tick(mk_tick(12000, 8000, 5000, 0));
    send_tick(mk_tick(1081, 1000, 300, 30000));
    send_tick(mk_tick(1082, 1000, 300, 30000));
    send_tick(mk_tick(1000, 1081, -300, 30000));
    send_tick(mk_tick(1000, 1082, -300, 30000));
    // Roughly a quarter turn per request, sweeping every quadrant both ways.
    for (int k = 0; k < 8; k++) send_tick(mk_tick(20000, 20000, 9000, 40000));
    for (int k = 0; k < 4; k++) send_tick(mk_tick(-20000, -20000, -9000, 40000));
    send_tick(mk_tick(-1, -1, -1, 1));
    drain();

    configure($urandom_range(65535), $urandom_range(65535), $urandom_range(400, 20),
              $urandom_range(65535));
    run_phase(0, 0, PHASE_ITEMS);

    configure(65535, 65535, 32767, 65535);
    run_phase(66, 0, PHASE_ITEMS);

    // Zero threshold: the fused rate is always used.
    configure($urandom_range(65535), 0, 0, $urandom_range(65535));
    run_phase(0, 66, PHASE_ITEMS);

    configure(0, $urandom_range(65535), $urandom_range(2000), 65535);
    run_phase(28, 28, PHASE_ITEMS);

    // Straight drive at full speed with no turn gain, forward and then back.
    configure($urandom_range(65535), 0, int'(AGREE_THRESHOLD_RST), 0);
    idle_pct  = 0;
    stall_pct <= 0;
    for (int k = 0; k < DRIVE_OUT; k++) begin
      send_tick(mk_tick(32767, 32767, $urandom_range(65535), 65535 - $urandom_range(63)));
    end
    for (int k = 0; k < DRIVE_BACK; k++) begin
      send_tick(mk_tick(-32768, -32768, $urandom_range(65535), 65535 - $urandom_range(63)));
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d poses checked, %0d on the gyro-only path, %0d on the fused path.",
             poses_checked, agree_ticks, fused_ticks);
    $display("Summary: %0d updates clamped a position; %0d mismatches over five phases.",
             clamped_ticks, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("diff_drive_odometry_gyro_fusion_unit verification clean");
    end else begin
      $display("diff_drive_odometry_gyro_fusion_unit verification failed");
    end
    $finish;
  end

endmodule
